// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the sound generator RTL.
// Relies on the including module having signals named clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked outside reset only.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== hdl/psg_pkg.sv =====
// Shared types, widths, register indexes and the write-mask function
// for the three-voice sound generator. No dependencies.
package psg_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int BASE_W        = 28;
  localparam int ACC_SUM_W     = ((BASE_W > FRACTION_BITS) ? BASE_W : FRACTION_BITS) + 1;
  localparam int INCR_W        = ACC_SUM_W - FRACTION_BITS;
  localparam int CNT_W         = 17;
  localparam int CNT_SUM_W     = ((CNT_W > INCR_W) ? CNT_W : INCR_W) + 1;
  localparam int OUT_W         = 24;

  localparam logic [BASE_W-1:0] BASE_RESET = 28'h100_0000;

  typedef enum logic [1:0] {
    MODE_LATCH = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ENV_STOP = 2'd0,
    ENV_UP   = 2'd1,
    ENV_DOWN = 2'd2
  } env_dir_t;

  // register indexes
  localparam logic [3:0] REG_TONE_A_HI = 4'd1;
  localparam logic [3:0] REG_TONE_B_HI = 4'd3;
  localparam logic [3:0] REG_TONE_C_HI = 4'd5;
  localparam logic [3:0] REG_NOISE_PER = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;
  localparam logic [3:0] REG_VOL_B     = 4'd9;
  localparam logic [3:0] REG_VOL_C     = 4'd10;
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

  // one generator advance request
  typedef struct packed {
    logic              tick;
    logic [INCR_W-1:0] incr;
  } psg_step_t;

  function automatic logic [7:0] psg_mask(input logic [3:0] r, input logic [7:0] v);
    logic [7:0] m;
    case (r)
      REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: m = v & 8'h0F;
      REG_NOISE_PER, REG_VOL_A, REG_VOL_B, REG_VOL_C: m = v & 8'h1F;
      default: m = v;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/psg_tone.sv =====
// One tone channel: period register, counter and square-wave flip-flop.
// Depends on psg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module psg_tone
  import psg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  psg_step_t   step,
  input  logic        period_load,
  input  logic [11:0] period_new,
  output logic        tone_next
);

  logic [11:0]          period, period_next;
  logic [CNT_W-1:0]     count, count_next;
  logic                 tone;
  logic [CNT_SUM_W-1:0] sum;

  always_comb begin
    sum         = CNT_SUM_W'(count) + CNT_SUM_W'(step.incr);
    period_next = period;
    count_next  = count;
    tone_next   = tone;
    if (period_load) begin
      period_next = period_new;
      if (period_new == 12'd0) tone_next = 1'b0;
    end else if (step.tick) begin
      if (sum >= CNT_SUM_W'(period)) begin
        count_next = '0;
        if (period != 12'd0) tone_next = ~tone;
      end else begin
        count_next = sum[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= 12'd1;
      count  <= '0;
      tone   <= 1'b0;
    end else begin
      period <= period_next;
      count  <= count_next;
      tone   <= tone_next;
    end
  end

  // a silenced channel never toggles
  `ASSERT_CLK(a_tone_zero_period, (period == 12'd0) |-> !tone)

endmodule

// ===== hdl/psg_noise.sv =====
// Noise generator: period register, counter and 17-bit LFSR.
// Depends on psg_pkg.
module psg_noise
  import psg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  psg_step_t  step,
  input  logic       period_load,
  input  logic [5:0] period_new,
  output logic       noise_next
);

  logic [5:0]           period, period_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [16:0]          shift, shift_next;
  logic [CNT_SUM_W-1:0] sum;

  always_comb begin
    sum         = CNT_SUM_W'(count) + CNT_SUM_W'(step.incr);
    period_next = period;
    count_next  = count;
    shift_next  = shift;
    if (period_load) begin
      period_next = period_new;
    end else if (step.tick) begin
      if (sum >= CNT_SUM_W'(period)) begin
        count_next = '0;
        shift_next = {shift[0] ^ shift[2], shift[16:1]};
      end else begin
        count_next = sum[CNT_W-1:0];
      end
    end
    noise_next = shift_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= 6'd1;
      count  <= '0;
      shift  <= 17'd1;
    end else begin
      period <= period_next;
      count  <= count_next;
      shift  <= shift_next;
    end
  end

endmodule

// ===== hdl/psg_env.sv =====
// Shared 32-step envelope: period, counter, shape decode and step logic.
// Depends on psg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module psg_env
  import psg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  psg_step_t   step,
  input  logic        period_load,
  input  logic [15:0] period_new,
  input  logic        shape_load,
  input  logic [3:0]  shape,
  output logic [4:0]  level_next
);

  logic [15:0]          period, period_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [4:0]           lvl;
  env_dir_t             dir, dir_next;
  logic                 hold, alt, fin;
  logic                 hold_next, alt_next, fin_next;
  logic [CNT_SUM_W-1:0] sum;
  logic [3:0]           sh;
  logic [4:0]           adv_lvl;
  env_dir_t             adv_dir;
  logic                 over;

  always_comb begin
    // shapes 0..3 behave as 9, 4..7 as 15
    sh = shape;
    if (shape[3:2] == 2'b00) sh = 4'd9;
    else if (shape[3:2] == 2'b01) sh = 4'd15;

    // an alternating bounce turns round and stays on the end step
    over    = 1'b0;
    adv_lvl = lvl;
    adv_dir = dir;
    case (dir)
      ENV_UP: begin
        if (lvl == 5'h1F) begin
          over = 1'b1;
          if (alt) begin
            adv_dir = ENV_DOWN;
            adv_lvl = 5'h1F;
          end else begin
            adv_lvl = 5'h00;
          end
        end else begin
          adv_lvl = lvl + 5'd1;
        end
      end
      ENV_DOWN: begin
        if (lvl == 5'h00) begin
          over = 1'b1;
          if (alt) begin
            adv_dir = ENV_UP;
            adv_lvl = 5'h00;
          end else begin
            adv_lvl = 5'h1F;
          end
        end else begin
          adv_lvl = lvl - 5'd1;
        end
      end
      default: ;
    endcase
    if (over && hold) begin
      adv_dir = ENV_STOP;
      adv_lvl = fin ? 5'h1F : 5'h00;
    end

    sum         = CNT_SUM_W'(count) + CNT_SUM_W'(step.incr);
    period_next = period;
    count_next  = count;
    level_next  = lvl;
    dir_next    = dir;
    hold_next   = hold;
    alt_next    = alt;
    fin_next    = fin;
    if (period_load) begin
      period_next = period_new;
    end else if (shape_load) begin
      hold_next  = sh[0];
      fin_next   = sh[2] ^ sh[1];
      alt_next   = sh[1] & ~sh[0];
      count_next = '0;
      level_next = sh[2] ? 5'h00 : 5'h1F;
      dir_next   = sh[2] ? ENV_UP : ENV_DOWN;
    end else if (step.tick) begin
      if (sum >= CNT_SUM_W'(period)) begin
        count_next = '0;
        level_next = adv_lvl;
        dir_next   = adv_dir;
      end else begin
        count_next = sum[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= 16'd1;
      count  <= '0;
      lvl    <= 5'd0;
      dir    <= ENV_STOP;
      hold   <= 1'b0;
      alt    <= 1'b0;
      fin    <= 1'b0;
    end else begin
      period <= period_next;
      count  <= count_next;
      lvl    <= level_next;
      dir    <= dir_next;
      hold   <= hold_next;
      alt    <= alt_next;
      fin    <= fin_next;
    end
  end

  // a stopped envelope only moves on a new shape
  `ASSERT_CLK(a_env_stopped, (dir == ENV_STOP && !shape_load) |=> $stable(lvl))

endmodule

// ===== hdl/psg_three_voice_tone_noise_envelope.sv =====
// Top level of the three-voice sound generator: stream ports, register file,
// mixer and volumes. Depends on psg_pkg, psg_tone, psg_noise, psg_env and
// assert_macros.svh.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the mode (latch
//   address, write data, read data, tick) and s_tdata the byte. Each request
//   gives exactly one result on the m_ stream: the read byte (zero unless a
//   read) and the three 5-bit channel levels after the request took effect.
//   cfg_valid/cfg_data load base_increment (24 fraction bits); write it only
//   while no request is in flight. cfg_ready is always high.
//   Path: an accepted request is registered in the input register, then
//   processed into the result register, which raises m_tvalid.
//   Throughput: one request per clock while the receiver takes results, set
//   by the combinational update of all counters, LFSR and envelope between
//   the input and result registers. When the receiver stalls, the result is
//   held; one further request is taken into the input register and then
//   s_tready drops until the result is taken.
//   Reset (rst, synchronous): register file, counters and handshakes clear,
//   all periods become one and base_increment returns to 1.0.
`include "assert_macros.svh"
module psg_three_voice_tone_noise_envelope
  import psg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BASE_W-1:0] cfg_data,   // base_increment
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,    // [7:0] data
  input  logic [1:0]        s_tuser,    // [1:0] mode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata     // [7:0] read_data, [12:8] level_a,
                                        // [17:13] level_b, [22:18] level_c
);

  logic                     in_valid;
  mode_t                    in_mode;
  logic [7:0]               in_data;
  logic                     advance;
  logic                     out_valid;
  logic [OUT_W-1:0]         out_data;

  logic [7:0]               rf [16];
  logic [3:0]               addr;
  logic [FRACTION_BITS-1:0] acc;
  logic [BASE_W-1:0]        base;
  logic [ACC_SUM_W-1:0]     acc_sum;
  psg_step_t                step;
  logic                     is_wr;
  logic [7:0]               wval;
  logic [7:0]               read_byte;

  logic [2:0]               tone_en, tone_en_next;
  logic [2:0]               noise_en, noise_en_next;
  logic [2:0]               use_env, use_env_next;
  logic [4:0]               vol [3];
  logic [4:0]               vol_next [3];
  logic [4:0]               level [3];
  logic [2:0]               tone_next;
  logic                     noise_next;
  logic [4:0]               env_next;

  logic [7:0]               env_lo, env_hi;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_comb begin
    acc_sum   = ACC_SUM_W'(acc) + ACC_SUM_W'(base);
    step.tick = advance && (in_mode == MODE_TICK);
    step.incr = acc_sum[ACC_SUM_W-1:FRACTION_BITS];
    is_wr     = advance && (in_mode == MODE_WRITE);
    wval      = psg_mask(addr, in_data);
    read_byte = (in_mode == MODE_READ) ? rf[addr] : 8'h00;
    env_lo    = (addr == REG_ENV_LO) ? wval : rf[REG_ENV_LO];
    env_hi    = (addr == REG_ENV_HI) ? wval : rf[REG_ENV_HI];
  end

  // tone channels, period taken from the register pair including this write
  for (genvar ch = 0; ch < 3; ch++) begin : g_tone
    localparam logic [3:0] LoIdx = 4'(2 * ch);
    localparam logic [3:0] HiIdx = 4'(2 * ch + 1);
    logic [7:0] lo, hi;
    logic       load;

    assign lo   = (addr == LoIdx) ? wval : rf[LoIdx];
    assign hi   = (addr == HiIdx) ? wval : rf[HiIdx];
    assign load = is_wr && (addr == LoIdx || addr == HiIdx);

    psg_tone u_tone (
      .clk         (clk),
      .rst         (rst),
      .step        (step),
      .period_load (load),
      .period_new  ({hi[3:0], lo}),
      .tone_next   (tone_next[ch])
    );
  end

  psg_noise u_noise (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .period_load (is_wr && addr == REG_NOISE_PER),
    .period_new  ({wval[4:0], 1'b1}),
    .noise_next  (noise_next)
  );

  psg_env u_env (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .period_load (is_wr && (addr == REG_ENV_LO || addr == REG_ENV_HI)),
    .period_new  ({env_hi, env_lo}),
    .shape_load  (is_wr && addr == REG_ENV_SHAPE),
    .shape       (wval[3:0]),
    .level_next  (env_next)
  );

  // mixer, volumes and gated levels after this request
  always_comb begin
    tone_en_next  = tone_en;
    noise_en_next = noise_en;
    if (is_wr && addr == REG_MIXER) begin
      tone_en_next  = ~wval[2:0];
      noise_en_next = ~wval[5:3];
    end
    for (int ch = 0; ch < 3; ch++) begin
      use_env_next[ch] = use_env[ch];
      vol_next[ch]     = vol[ch];
      if (is_wr && addr == (REG_VOL_A + 4'(ch))) begin
        use_env_next[ch] = wval[4];
        vol_next[ch]     = {wval[3:0], 1'b1};
      end
      if ((tone_next[ch] & tone_en_next[ch]) | (noise_next & noise_en_next[ch]))
        level[ch] = 5'd0;
      else
        level[ch] = use_env_next[ch] ? env_next : vol_next[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode <= mode_t'(s_tuser);
      in_data <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {1'b0, level[2], level[1], level[0], read_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf       <= '{default: 8'h00};
      addr     <= 4'd0;
      acc      <= '0;
      base     <= BASE_RESET;
      tone_en  <= 3'b000;
      noise_en <= 3'b000;
      use_env  <= 3'b000;
      vol      <= '{default: 5'd0};
    end else begin
      if (cfg_valid) base <= cfg_data;
      if (is_wr) rf[addr] <= wval;
      if (advance && in_mode == MODE_LATCH) addr <= in_data[3:0];
      if (step.tick) acc <= acc_sum[FRACTION_BITS-1:0];
      tone_en  <= tone_en_next;
      noise_en <= noise_en_next;
      use_env  <= use_env_next;
      vol      <= vol_next;
    end
  end

  // a free result register never blocks the input side
  `ASSERT_CLK(a_ready_when_free, (!m_tvalid || m_tready) |-> s_tready)
  // a request waiting in the input register is kept intact
  `ASSERT_CLK(a_in_hold, (in_valid && !advance) |=> (in_valid && $stable(in_data) && $stable(in_mode)))
  // reset empties both stages
  `ASSERT_ALWAYS(a_reset_empty, rst |=> (!m_tvalid && !in_valid))

endmodule

// ===== test/psg_three_voice_tone_noise_envelope_tb.sv =====
// Self-checking bench for psg_three_voice_tone_noise_envelope: a directed table, then
// random register traffic and ticks, checked against an in-bench model or typed rows.
// Depends on psg_pkg and the RTL only.
`timescale 1ns / 100ps
module psg_three_voice_tone_noise_envelope_tb;
  import psg_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int ROWS        = 24;
  localparam int PHASES      = 6;

  // registers with no name in the package
  localparam logic [3:0] REG_TONE_A_LO = 4'd0;
  localparam logic [3:0] REG_TONE_B_LO = 4'd2;
  localparam logic [3:0] REG_TONE_C_LO = 4'd4;

  // the shapes that 0..3 and 4..7 fold onto
  localparam logic [3:0] SHAPE_DECAY_HOLD  = 4'd9;
  localparam logic [3:0] SHAPE_ATTACK_DROP = 4'd15;

  typedef struct packed {
    logic       pad;
    logic [4:0] lvl_c;
    logic [4:0] lvl_b;
    logic [4:0] lvl_a;
    logic [7:0] rd;
  } psg_result_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  data;
    logic        typed_check;
    psg_result_t result;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BASE_W-1:0] cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  psg_three_voice_tone_noise_envelope dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model state
  logic [7:0]  regs [16];
  logic [3:0]  addr_latch;
  int unsigned base_inc;
  int unsigned frac_acc;
  logic [11:0] tone_per [3];
  int unsigned tone_cnt [3];
  logic        tone_out [3];
  logic        tone_en [3];
  logic        noise_en [3];
  logic [4:0]  vol [3];
  logic        env_sel [3];
  int unsigned noise_per;
  int unsigned noise_cnt;
  logic [16:0] lfsr;
  int unsigned env_per;
  int unsigned env_cnt;
  logic [4:0]  env_level;
  env_dir_t    env_dir;
  logic        env_hold;
  logic        env_alt;
  logic        env_final;

  psg_result_t predicted_outputs [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  stim_row_t directed_rows [ROWS] = '{
    '{MODE_READ,  8'h00, 1'b1, 24'h000000},  // everything cleared after reset
    '{MODE_TICK,  8'hFF, 1'b1, 24'h000000},  // envelope stopped, volumes zero
    '{MODE_LATCH, 8'hF8, 1'b0, '0},          // high nibble of the address ignored
    '{MODE_WRITE, 8'hFF, 1'b0, '0},
    '{MODE_READ,  8'h00, 1'b1, 24'h00001F},  // volume register keeps 5 bits
    '{MODE_LATCH, 8'h07, 1'b0, '0},
    '{MODE_WRITE, 8'h00, 1'b0, '0},          // all tones and noise enabled
    '{MODE_TICK,  8'h00, 1'b0, '0},
    '{MODE_LATCH, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 8'h00, 1'b0, '0},          // zero tone period clears the output
    '{MODE_TICK,  8'h5A, 1'b0, '0},
    '{MODE_LATCH, 8'h0B, 1'b0, '0},
    '{MODE_WRITE, 8'h00, 1'b0, '0},          // zero envelope period: step every tick
    '{MODE_LATCH, 8'h0D, 1'b0, '0},
    '{MODE_WRITE, 8'hF2, 1'b0, '0},          // low shape folds to decay-hold
    '{MODE_TICK,  8'h00, 1'b0, '0},
    '{MODE_TICK,  8'hA5, 1'b0, '0},
    '{MODE_WRITE, 8'h0B, 1'b0, '0},          // hold with alternate
    '{MODE_TICK,  8'h00, 1'b0, '0},
    '{MODE_WRITE, 8'h0E, 1'b0, '0},          // alternating triangle
    '{MODE_TICK,  8'h00, 1'b0, '0},
    '{MODE_LATCH, 8'h06, 1'b0, '0},
    '{MODE_WRITE, 8'hFF, 1'b0, '0},          // longest noise period
    '{MODE_READ,  8'h00, 1'b0, '0}
  };

  task automatic psg_model_reset();
    for (int ch = 0; ch < 3; ch++) begin
      tone_per[ch] = 12'd1;
      tone_cnt[ch] = 0;
      tone_out[ch] = 1'b0;
      tone_en[ch]  = 1'b0;
      noise_en[ch] = 1'b0;
      vol[ch]      = '0;
      env_sel[ch]  = 1'b0;
    end
    for (int r = 0; r < 16; r++) regs[r] = '0;
    addr_latch = '0;
    base_inc   = 32'(BASE_RESET);
    frac_acc   = 0;
    noise_per  = 1;
    noise_cnt  = 0;
    lfsr       = 17'd1;
    env_per    = 1;
    env_cnt    = 0;
    env_level  = '0;
    env_dir    = ENV_STOP;
    env_hold   = 1'b0;
    env_alt    = 1'b0;
    env_final  = 1'b0;
  endtask

  // Applies one request to the model and returns the result it should give.
  task automatic psg_apply_request(input mode_t mode, input logic [7:0] data,
                                   output psg_result_t res);
    logic [7:0]  v;
    logic [3:0]  shape;
    logic [4:0]  lvl [3];
    int          ch;
    int          s;
    int          d;
    int unsigned sum;
    int unsigned incr;
    res = '0;
    case (mode)
      MODE_LATCH: addr_latch = data[3:0];
      MODE_WRITE: begin
        v = data;
        case (addr_latch)
          REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: v = v & 8'h0F;
          REG_NOISE_PER, REG_VOL_A, REG_VOL_B, REG_VOL_C: v = v & 8'h1F;
          default: ;
        endcase
        regs[addr_latch] = v;
        if (addr_latch <= REG_TONE_C_HI) begin
          ch = int'(addr_latch >> 1);
          tone_per[ch] = {regs[2 * ch + 1][3:0], regs[2 * ch]};
          if (tone_per[ch] == 12'd0) tone_out[ch] = 1'b0;
        end else if (addr_latch == REG_NOISE_PER) begin
          noise_per = 2 * 32'(v) + 1;
        end else if (addr_latch == REG_MIXER) begin
          for (int c = 0; c < 3; c++) begin
            tone_en[c]  = ~v[c];
            noise_en[c] = ~v[c + 3];
          end
        end else if (addr_latch >= REG_VOL_A && addr_latch <= REG_VOL_C) begin
          ch = int'(addr_latch - REG_VOL_A);
          env_sel[ch] = v[4];
          vol[ch]     = {v[3:0], 1'b1};
        end else if (addr_latch == REG_ENV_LO || addr_latch == REG_ENV_HI) begin
          env_per = 32'({regs[REG_ENV_HI], regs[REG_ENV_LO]});
        end else if (addr_latch == REG_ENV_SHAPE) begin
          shape = v[3:0];
          if (shape < 4'd4) shape = SHAPE_DECAY_HOLD;
          else if (shape < 4'd8) shape = SHAPE_ATTACK_DROP;
          env_hold  = shape[0];
          env_final = shape[2] ^ shape[1];
          env_alt   = shape[1] & ~shape[0];
          env_cnt   = 0;
          if (shape[2]) begin
            env_level = 5'd0;
            env_dir   = ENV_UP;
          end else begin
            env_level = 5'd31;
            env_dir   = ENV_DOWN;
          end
        end
      end
      MODE_READ: res.rd = regs[addr_latch];
      default: begin
        sum      = frac_acc + base_inc;
        incr     = sum >> FRACTION_BITS;
        frac_acc = sum & ((1 << FRACTION_BITS) - 1);
        if (env_cnt + incr >= env_per) begin
          env_cnt = 0;
          s = int'(env_level);
          d = (env_dir == ENV_UP) ? 1 : ((env_dir == ENV_DOWN) ? -1 : 0);
          s += d;
          if (s < 0 || s > 31) begin
            // past either end: bounce back when alternating, else wrap
            if (env_alt) begin
              d = -d;
              s += d;
            end else begin
              s = s & 31;
            end
            if (env_hold) begin
              d = 0;
              s = env_final ? 31 : 0;
            end
          end
          env_level = s[4:0];
          env_dir   = (d > 0) ? ENV_UP : ((d < 0) ? ENV_DOWN : ENV_STOP);
        end else begin
          env_cnt += incr;
        end
        if (noise_cnt + incr >= noise_per) begin
          noise_cnt = 0;
          lfsr = {lfsr[0] ^ lfsr[2], lfsr[16:1]};
        end else begin
          noise_cnt += incr;
        end
        for (int c = 0; c < 3; c++) begin
          if (tone_cnt[c] + incr >= tone_per[c]) begin
            tone_cnt[c] = 0;
            if (tone_per[c] != 12'd0) tone_out[c] = ~tone_out[c];
          end else begin
            tone_cnt[c] += incr;
          end
        end
      end
    endcase
    for (int c = 0; c < 3; c++) begin
      if ((tone_out[c] & tone_en[c]) | (lfsr[1] & noise_en[c])) lvl[c] = '0;
      else lvl[c] = env_sel[c] ? env_level : vol[c];
    end
    res.lvl_a = lvl[0];
    res.lvl_b = lvl[1];
    res.lvl_c = lvl[2];
  endtask

  // ---------------------------------------------------------------- sender
  task automatic send_request(input mode_t mode, input logic [7:0] data,
                              input logic typed_check, input psg_result_t typed_result);
    psg_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    psg_apply_request(mode, data, res);
    predicted_outputs.push_back(typed_check ? typed_result : res);
  endtask

  function automatic logic [7:0] pick_write_data(input logic [3:0] addr);
    logic [7:0] v;
    v = 8'($urandom);
    case (addr)
      // short periods so that tones and the envelope move within a few ticks
      REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO, REG_ENV_LO:
        if ($urandom_range(0, 1) == 0) v = 8'($urandom_range(0, 6));
      REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_ENV_HI:
        if ($urandom_range(0, 3) != 0) v = 8'h00;
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_random(input int count);
    int          sent;
    int          pick;
    logic [3:0]  addr;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      addr = 4'($urandom_range(0, 15));
      if (pick < 40) begin
        send_request(MODE_TICK, 8'($urandom), 1'b0, '0);
        sent += 1;
      end else if (pick < 75) begin
        send_request(MODE_LATCH, {4'($urandom), addr}, 1'b0, '0);
        send_request(MODE_WRITE, pick_write_data(addr), 1'b0, '0);
        sent += 2;
      end else if (pick < 85) begin
        send_request(MODE_LATCH, {4'($urandom), addr}, 1'b0, '0);
        send_request(MODE_READ, 8'($urandom), 1'b0, '0);
        sent += 2;
      end else begin
        send_request(mode_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
        sent += 1;
      end
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_base_increment(input logic [BASE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_inc = 32'(value);
  endtask

  // ---------------------------------------------------------------- receiver
  task automatic report_field(input string field, input int exp_val, input int got_val);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, got_val);
  endtask

  initial begin
    psg_result_t got;
    psg_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = psg_result_t'(m_tdata);
        if (predicted_outputs.size() == 0) begin
          report_field("unexpected result", 0, int'(m_tdata));
        end else begin
          want = predicted_outputs.pop_front();
          if (got.rd !== want.rd)
            report_field("read_data", int'(want.rd), int'(got.rd));
          if (got.lvl_a !== want.lvl_a)
            report_field("level_a", int'(want.lvl_a), int'(got.lvl_a));
          if (got.lvl_b !== want.lvl_b)
            report_field("level_b", int'(want.lvl_b), int'(got.lvl_b));
          if (got.lvl_c !== want.lvl_c)
            report_field("level_c", int'(want.lvl_c), int'(got.lvl_c));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // no request moving on any channel for too long means a hang
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [BASE_W-1:0] base;
    int                count;
    psg_model_reset();
    send_idle_pct  = 24;
    recv_stall_pct = 78;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < ROWS; i++)
      send_request(directed_rows[i].mode, directed_rows[i].data,
                   directed_rows[i].typed_check, directed_rows[i].result);

    for (int p = 0; p < PHASES; p++) begin
      count = 150;
      if (p > 0) begin
        drain_results();
        case (p)
          1: base = 28'hFFF_FFFF;                         // largest step per tick
          2: begin base = 28'h000_0000; count = 100; end  // nothing but zero periods move
          3: base = 28'h180_0000;                         // one and a half
          4: base = 28'($urandom);
          default: begin base = 28'h040_0000; count = 100; end
        endcase
        load_base_increment(base);
        if (p >= 4) begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end else if (p >= 2) begin
          send_idle_pct  = 78;
          recv_stall_pct = 24;
        end
      end
      run_random(count);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
